[design/rosup_pkg.sv]
// ----------------------------------------------------------------------------
// Rectangle overlap suppression package
// Mode codes used by the table, and the fixed widths of its count fields and read index.
// ----------------------------------------------------------------------------
package rosup_pkg;

    // Item modes; the last code is unused and changes nothing.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNDEF  = 2'd3;

    // Fixed widths of the count fields and the read index.
    localparam int CNT_W = 5;
    localparam int IDX_W = 4;

endpackage

[design/rosup_mem.sv]
// ----------------------------------------------------------------------------
// Rectangle table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rosup_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/rosup_ovl.sv]
// ----------------------------------------------------------------------------
// Overlap datapath
// Two stages: intersection spans, then overlap area and stored entry area.
// ----------------------------------------------------------------------------
module rosup_ovl #(
    parameter int COORD_BITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [4*COORD_BITS-1:0] i_entry,
    input  logic [4*COORD_BITS-1:0] i_new,
    output logic                    o_s1_valid,
    output logic                    o_valid,
    output logic [4*COORD_BITS-1:0] o_entry,
    output logic [2*COORD_BITS-1:0] o_ov,
    output logic [2*COORD_BITS-1:0] o_ae
);

    localparam int C = COORD_BITS;

    logic [C-1:0] ex, ey, ew, eh, nx, ny, nw, nh;
    logic [C:0]   x0, y0, x1, y1, ex1, ey1, nx1, ny1;
    logic [C-1:0] n_dx, n_dy;

    logic           r_s1v, r_s2v;
    logic [4*C-1:0] r_e1, r_e2;
    logic [C-1:0]   r_dx, r_dy;
    logic [2*C-1:0] r_ov, r_ae;

    assign {ex, ey, ew, eh} = i_entry;
    assign {nx, ny, nw, nh} = i_new;

    // Intersection spans; an empty span gives zero.
    always_comb begin
        ex1  = {1'b0, ex} + {1'b0, ew};
        ey1  = {1'b0, ey} + {1'b0, eh};
        nx1  = {1'b0, nx} + {1'b0, nw};
        ny1  = {1'b0, ny} + {1'b0, nh};
        x0   = (ex > nx) ? {1'b0, ex} : {1'b0, nx};
        y0   = (ey > ny) ? {1'b0, ey} : {1'b0, ny};
        x1   = (ex1 < nx1) ? ex1 : nx1;
        y1   = (ey1 < ny1) ? ey1 : ny1;
        n_dx = (x1 > x0) ? C'(x1 - x0) : '0;
        n_dy = (y1 > y0) ? C'(y1 - y0) : '0;
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
        end else begin
            r_s1v <= i_valid;
            r_s2v <= r_s1v;
        end
    end

    // Span stage, then product stage.
    always_ff @(posedge i_clk) begin
        r_e1 <= i_entry;
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_e2 <= r_e1;
        r_ov <= r_dx * r_dy;
        r_ae <= r_e1[2*C-1:C] * r_e1[C-1:0];
    end

    assign o_s1_valid = r_s1v;
    assign o_valid    = r_s2v;
    assign o_entry    = r_e2;
    assign o_ov       = r_ov;
    assign o_ae       = r_ae;

endmodule

[design/rect_overlap_suppress_table.sv]
// ----------------------------------------------------------------------------
// Rectangle overlap suppression table
// Ordered table of rectangles with overlap-ratio suppression on insert.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  input    | i_valid / o_ready  | i_mode, i_rect_x/y/w/h, i_read_index
//  output   | o_valid / i_ready  | o_accepted, o_removed_count, o_entry_count,
//           |                    | o_table_full, o_out_valid, o_out_x/y/w/h
//
// An insert streams the stored entries through a read and compute pipeline
// (memory read register, span stage, product stage), one entry per cycle,
// writing kept entries back in compacted order. Read, clear and mode 3 skip the walk.
// Reset empties the table at once; memory contents need no clearing.
// A result waits in the output register until taken; the next item is
// accepted meanwhile and completes when the output register is free.
// ----------------------------------------------------------------------------
module rect_overlap_suppress_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int COORD_BITS  = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_mode,
    input  logic [COORD_BITS-1:0] i_rect_x,
    input  logic [COORD_BITS-1:0] i_rect_y,
    input  logic [COORD_BITS-1:0] i_rect_w,
    input  logic [COORD_BITS-1:0] i_rect_h,
    input  logic [3:0]            i_read_index,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_accepted,
    output logic [4:0]            o_removed_count,
    output logic [4:0]            o_entry_count,
    output logic                  o_table_full,
    output logic                  o_out_valid,
    output logic [COORD_BITS-1:0] o_out_x,
    output logic [COORD_BITS-1:0] o_out_y,
    output logic [COORD_BITS-1:0] o_out_w,
    output logic [COORD_BITS-1:0] o_out_h
);

    localparam int C  = COORD_BITS;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_DRAIN, S_DONE, S_RDWAIT, S_RDDONE
    } t_state;

    t_state          r_state;
    logic [1:0]      r_mode;
    logic [4*C-1:0]  r_new;
    logic [2*C-1:0]  r_an;
    logic [3:0]      r_idx;
    logic [CW-1:0]   r_cnt, r_rd, r_wr, r_rem;
    logic            r_rej, r_mv, r_hit;

    logic            r_ovld, r_oacc, r_ofull, r_oval;
    logic [4:0]      r_orem, r_ocnt;
    logic [4*C-1:0]  r_orect;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [4*C-1:0]  mem_wdata, mem_rdata;

    logic            ovl_s1v, ovl_v;
    logic [4*C-1:0]  ovl_entry;
    logic [2*C-1:0]  ovl_ov, ovl_ae;

    logic [2*C+2:0]  ov5, an2, ae2;
    logic            nz, rej_here, kill, out_free, out_load, idx_hit;

    // State memory and overlap datapath.
    rosup_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(4*C)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rosup_ovl #(.COORD_BITS(C)) u_ovl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_mv),
        .i_entry    (mem_rdata),
        .i_new      (r_new),
        .o_s1_valid (ovl_s1v),
        .o_valid    (ovl_v),
        .o_entry    (ovl_entry),
        .o_ov       (ovl_ov),
        .o_ae       (ovl_ae)
    );

    // Suppression decision for the entry leaving the datapath.
    always_comb begin
        ov5      = {1'b0, ovl_ov, 2'b00} + {3'b000, ovl_ov};
        an2      = {2'b00, r_an, 1'b0};
        ae2      = {2'b00, ovl_ae, 1'b0};
        nz       = (ovl_ov != '0);
        rej_here = ovl_v && !r_rej && nz && (ov5 >= an2);
        kill     = ovl_v && !r_rej && nz && !(ov5 >= an2) && (ov5 >= ae2);
        out_free = !r_ovld || i_ready;
        out_load = out_free && ((r_state == S_DONE) || (r_state == S_RDDONE));
        idx_hit  = (32'(i_read_index) < 32'(r_cnt));
    end

    // Memory port selection: compacted write-back, or the final append.
    // A read holds its index on the read port until the result is loaded.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr[AW-1:0];
        mem_wdata = ovl_entry;
        if (r_state == S_IDLE) begin
            mem_raddr = AW'(i_read_index);
        end else if (r_mode == rosup_pkg::MODE_READ) begin
            mem_raddr = AW'(r_idx);
        end else begin
            mem_raddr = r_rd[AW-1:0];
        end
        if (ovl_v && !kill) begin
            mem_we = 1'b1;
        end else if (r_state == S_DONE && r_mode == rosup_pkg::MODE_INSERT &&
                     out_free && !r_rej && 32'(r_wr) < TABLE_DEPTH) begin
            mem_we    = 1'b1;
            mem_wdata = r_new;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // Entry issue strobe: one stored entry enters the datapath per walk cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= (r_state == S_WALK) && (r_rd < r_cnt);
        end
    end

    // Control sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
            if (ovl_v) begin
                if (rej_here) begin
                    r_rej <= 1'b1;
                end
                if (kill) begin
                    r_rem <= r_rem + 1'b1;
                end else begin
                    r_wr <= r_wr + 1'b1;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode <= i_mode;
                        r_new  <= {i_rect_x, i_rect_y, i_rect_w, i_rect_h};
                        r_an   <= i_rect_w * i_rect_h;
                        r_idx  <= i_read_index;
                        r_hit  <= idx_hit;
                        r_rd   <= '0;
                        r_wr   <= '0;
                        r_rem  <= '0;
                        r_rej  <= 1'b0;
                        if (i_mode == rosup_pkg::MODE_INSERT) begin
                            r_state <= S_WALK;
                        end else if (i_mode == rosup_pkg::MODE_READ) begin
                            r_state <= S_RDWAIT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_WALK: begin
                    if (r_rd < r_cnt) begin
                        r_rd <= r_rd + 1'b1;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_mv && !ovl_s1v) begin
                        r_state <= S_DONE;
                    end
                end
                S_RDWAIT: begin
                    r_state <= S_RDDONE;
                end
                S_RDDONE: begin
                    if (out_free) begin
                        r_oacc   <= 1'b0;
                        r_ofull  <= 1'b0;
                        r_orem   <= '0;
                        r_ocnt   <= 5'(r_cnt);
                        r_oval   <= r_hit;
                        r_orect  <= r_hit ? mem_rdata : '0;
                        r_state  <= S_IDLE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_oval  <= 1'b0;
                        r_orect <= '0;
                        r_state <= S_IDLE;
                        case (r_mode)
                            rosup_pkg::MODE_INSERT: begin
                                r_orem <= 5'(r_rem);
                                if (r_rej) begin
                                    r_cnt   <= r_wr;
                                    r_ocnt  <= 5'(r_wr);
                                    r_oacc  <= 1'b0;
                                    r_ofull <= 1'b0;
                                end else if (32'(r_wr) < TABLE_DEPTH) begin
                                    r_cnt   <= r_wr + 1'b1;
                                    r_ocnt  <= 5'(r_wr + 1'b1);
                                    r_oacc  <= 1'b1;
                                    r_ofull <= 1'b0;
                                end else begin
                                    r_cnt   <= r_wr;
                                    r_ocnt  <= 5'(r_wr);
                                    r_oacc  <= 1'b0;
                                    r_ofull <= 1'b1;
                                end
                            end
                            rosup_pkg::MODE_CLEAR: begin
                                r_cnt   <= '0;
                                r_ocnt  <= '0;
                                r_oacc  <= 1'b0;
                                r_ofull <= 1'b0;
                                r_orem  <= '0;
                            end
                            default: begin
                                r_ocnt  <= 5'(r_cnt);
                                r_oacc  <= 1'b0;
                                r_ofull <= 1'b0;
                                r_orem  <= '0;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_ovld;
    assign o_accepted      = r_oacc;
    assign o_removed_count = r_orem;
    assign o_entry_count   = r_ocnt;
    assign o_table_full    = r_ofull;
    assign o_out_valid     = r_oval;
    assign {o_out_x, o_out_y, o_out_w, o_out_h} = r_orect;

endmodule

[design/rosup_chk.sv]
// ----------------------------------------------------------------------------
// Rectangle overlap suppression checker
// Port-level properties of the table, bound to the top level.
// ----------------------------------------------------------------------------
module rosup_chk #(
    parameter int COORD_BITS = 10
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic                  o_accepted,
    input logic [4:0]            o_removed_count,
    input logic [4:0]            o_entry_count,
    input logic                  o_table_full,
    input logic                  o_out_valid,
    input logic [COORD_BITS-1:0] o_out_x
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_entry_count) &&
            $stable(o_accepted) && $stable(o_removed_count))
        else $error("result changed while stalled");

    // An insert is never both appended and dropped.
    a_acc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_accepted && o_table_full))
        else $error("accepted and table_full both set");

    // A read result carries no insert flags.
    a_read_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_valid |-> !o_accepted && !o_table_full &&
            (o_removed_count == '0))
        else $error("read result with insert flags");

    // An appended rectangle leaves at least one entry stored.
    a_acc_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> (o_entry_count != '0))
        else $error("append with empty table");

    // Read data is zero unless the read hit a stored entry.
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_valid |-> (o_out_x == '0))
        else $error("read data without a hit");

endmodule

bind rect_overlap_suppress_table rosup_chk #(.COORD_BITS(COORD_BITS)) u_rosup_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_accepted      (o_accepted),
    .o_removed_count (o_removed_count),
    .o_entry_count   (o_entry_count),
    .o_table_full    (o_table_full),
    .o_out_valid     (o_out_valid),
    .o_out_x         (o_out_x)
);
